// ===== hw/rtl/bfr_pkg.sv =====
// Shared package for the brightness fade ramp.
// Holds the command codes, ramp constants, divider sizing and the sequencer state type.
// No dependencies.
package bfr_pkg;

    // Command codes carried on the input tuser field.
    localparam logic [1:0] FUNC_TICK     = 2'd0;
    localparam logic [1:0] FUNC_FADE_IN  = 2'd1;
    localparam logic [1:0] FUNC_FADE_OUT = 2'd2;

    // Field widths.
    localparam int FUNC_W   = 2;
    localparam int FRAMES_W = 8;
    localparam int BRIGHT_W = 4;
    localparam int ACC_W    = 13;
    localparam int STEP_W   = 12;

    // Full brightness in 5.8 fixed point, and the top brightness code.
    localparam logic [ACC_W-1:0]    FULL_LEVEL = 13'd3840;
    localparam logic [BRIGHT_W-1:0] MAX_BRIGHT = 4'd15;

    // Serial divider: a 12-bit dividend takes one quotient bit per cycle.
    localparam int DIV_STEPS = STEP_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EXEC,
        ST_OUT
    } bfr_state_t;

endpackage

// ===== hw/rtl/brightness_fade_ramp_top.sv =====
// Top level of the brightness fade ramp: command sequencer, ramp state and output register.
// Depends on bfr_pkg and bfr_div.
//
// Usage: each input request is a command. tuser selects it (0 frame tick, 1 start
// fade in, 2 start fade out); tdata carries the fade length in frames for starts.
// Every command produces exactly one output request holding the current 4-bit
// brightness and an active flag that stays high while a fade is still in progress.
// A start with a nonzero frame count runs the serial divider, which finds the 4.8
// step 3840 / frames at one quotient bit per cycle. The divider is launched at the
// accepting edge; when it is done, the sequencer updates the ramp state and then
// loads the output register.
// Ticks, zero-length starts and unused codes skip the divider and go straight
// to the ramp state update and the output register.
// The block handles one command at a time; s_axis_tready is high only while the
// sequencer is idle. Results go into an output register, so a new command is
// accepted while the previous result still waits; if the receiver stalls, the
// sequencer holds the finished result until the register frees up.
// Reset clears the ramp: no fade running, brightness black, no result pending.
module brightness_fade_ramp_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] frames
    input  logic [1:0] s_axis_tuser,    // [1:0] func
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata     // [3:0] brightness, [4] active, [7:5] zero
);

    bfr_pkg::bfr_state_t state_reg, state_next;

    // Latched command.
    logic [bfr_pkg::FUNC_W-1:0]   func_reg, func_next;
    logic [bfr_pkg::FRAMES_W-1:0] frames_reg, frames_next;

    // Ramp state.
    logic                         running_reg, running_next;
    logic                         fading_in_reg, fading_in_next;
    logic [bfr_pkg::ACC_W-1:0]    level_reg, level_next;
    logic [bfr_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [bfr_pkg::BRIGHT_W-1:0] shown_reg, shown_next;

    // Output register.
    logic                         out_valid_reg, out_valid_next;
    logic [bfr_pkg::BRIGHT_W-1:0] out_bright_reg, out_bright_next;
    logic                         out_active_reg, out_active_next;

    logic                         in_accept;
    logic                         is_start;
    logic                         needs_div;
    logic                         div_start;
    logic                         div_done;
    logic [bfr_pkg::STEP_W-1:0]   quotient;
    logic                         out_free;
    logic [bfr_pkg::ACC_W-1:0]    sum;
    logic [bfr_pkg::ACC_W-1:0]    diff;
    logic [bfr_pkg::ACC_W-1:0]    tick_level;
    logic                         tick_stop;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign is_start  = (s_axis_tuser == bfr_pkg::FUNC_FADE_IN) ||
                       (s_axis_tuser == bfr_pkg::FUNC_FADE_OUT);
    assign needs_div = is_start && (s_axis_tdata != '0);
    assign div_start = in_accept && needs_div;
    assign out_free  = !out_valid_reg || m_axis_tready;

    bfr_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (s_axis_tdata),
        .done     (div_done),
        .quotient (quotient)
    );

    // One add and one subtract of the step against the accumulator for a frame tick.
    // The accumulator stays at or below 3840, so the sum never wraps 13 bits.
    assign sum  = level_reg + {1'b0, step_reg};
    assign diff = level_reg - {1'b0, step_reg};

    always_comb
    begin
        if (fading_in_reg)
        begin
            tick_stop  = (sum >= bfr_pkg::FULL_LEVEL);
            tick_level = tick_stop ? bfr_pkg::FULL_LEVEL : sum;
        end
        else
        begin
            tick_stop  = (level_reg <= {1'b0, step_reg});
            tick_level = tick_stop ? '0 : diff;
        end
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bfr_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = needs_div ? bfr_pkg::ST_DIV : bfr_pkg::ST_EXEC;
                end
            end
            bfr_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = bfr_pkg::ST_EXEC;
                end
            end
            bfr_pkg::ST_EXEC:
            begin
                state_next = bfr_pkg::ST_OUT;
            end
            bfr_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = bfr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bfr_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs driven by the sequencer state.
    always_comb
    begin
        s_axis_tready   = 1'b0;
        func_next       = func_reg;
        frames_next     = frames_reg;
        running_next    = running_reg;
        fading_in_next  = fading_in_reg;
        level_next      = level_reg;
        step_next       = step_reg;
        shown_next      = shown_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_bright_next = out_bright_reg;
        out_active_next = out_active_reg;
        case (state_reg)
            bfr_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (in_accept)
                begin
                    func_next   = s_axis_tuser;
                    frames_next = s_axis_tdata;
                end
            end
            bfr_pkg::ST_DIV:
            begin
            end
            bfr_pkg::ST_EXEC:
            begin
                if (func_reg == bfr_pkg::FUNC_TICK)
                begin
                    if (running_reg)
                    begin
                        level_next   = tick_level;
                        running_next = !tick_stop;
                        shown_next   = tick_level[bfr_pkg::ACC_W-1] ? bfr_pkg::MAX_BRIGHT :
                                       tick_level[bfr_pkg::ACC_W-2:8];
                    end
                end
                else if ((func_reg == bfr_pkg::FUNC_FADE_IN) ||
                         (func_reg == bfr_pkg::FUNC_FADE_OUT))
                begin
                    if (frames_reg == '0)
                    begin
                        // Zero length jumps straight to the end level.
                        running_next = 1'b0;
                        shown_next   = (func_reg == bfr_pkg::FUNC_FADE_IN) ?
                                       bfr_pkg::MAX_BRIGHT : '0;
                    end
                    else
                    begin
                        running_next   = 1'b1;
                        fading_in_next = (func_reg == bfr_pkg::FUNC_FADE_IN);
                        level_next     = (func_reg == bfr_pkg::FUNC_FADE_IN) ?
                                         '0 : bfr_pkg::FULL_LEVEL;
                        step_next      = (quotient == '0) ?
                                         bfr_pkg::STEP_W'(1) : quotient;
                        shown_next     = (func_reg == bfr_pkg::FUNC_FADE_IN) ?
                                         '0 : bfr_pkg::MAX_BRIGHT;
                    end
                end
            end
            bfr_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_bright_next = shown_reg;
                    out_active_next = running_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfr_pkg::ST_IDLE;
            running_reg   <= 1'b0;
            fading_in_reg <= 1'b0;
            level_reg     <= '0;
            step_reg      <= '0;
            shown_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            running_reg   <= running_next;
            fading_in_reg <= fading_in_next;
            level_reg     <= level_next;
            step_reg      <= step_next;
            shown_reg     <= shown_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        frames_reg     <= frames_next;
        out_bright_reg <= out_bright_next;
        out_active_reg <= out_active_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_active_reg, out_bright_reg};

endmodule

// ===== hw/rtl/bfr_div.sv =====
// Restoring serial divider that computes FULL_LEVEL / divisor.
// One quotient bit per cycle, most significant bit first.
// Depends on bfr_pkg.
module bfr_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [bfr_pkg::FRAMES_W-1:0]      divisor,
    output logic                              done,
    output logic [bfr_pkg::STEP_W-1:0]        quotient
);

    logic                              busy_reg, busy_next;
    logic [bfr_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [bfr_pkg::FRAMES_W-1:0]      rem_reg, rem_next;
    logic [bfr_pkg::FRAMES_W-1:0]      dvs_reg, dvs_next;
    logic [bfr_pkg::STEP_W-1:0]        dvd_reg, dvd_next;
    logic [bfr_pkg::STEP_W-1:0]        quo_reg, quo_next;
    logic [bfr_pkg::FRAMES_W:0]        shifted;
    logic [bfr_pkg::FRAMES_W:0]        trial;
    logic                              last_step;

    assign last_step = (cnt_reg == bfr_pkg::DIV_CNT_W'(bfr_pkg::DIV_STEPS - 1));
    assign done      = busy_reg && last_step;
    assign quotient  = quo_reg;

    // Bring down the next dividend bit and try to subtract the divisor.
    assign shifted = {rem_reg, dvd_reg[bfr_pkg::STEP_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            dvd_next  = bfr_pkg::FULL_LEVEL[bfr_pkg::STEP_W-1:0];
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[bfr_pkg::STEP_W-2:0], 1'b0};
            if (!trial[bfr_pkg::FRAMES_W])
            begin
                rem_next = trial[bfr_pkg::FRAMES_W-1:0];
                quo_next = {quo_reg[bfr_pkg::STEP_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[bfr_pkg::FRAMES_W-1:0];
                quo_next = {quo_reg[bfr_pkg::STEP_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + bfr_pkg::DIV_CNT_W'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

endmodule

// ===== dv/brightness_fade_ramp_checker.sv =====
// Result checker for the brightness fade ramp: watches both streams and predicts every result.
// Keeps its own copy of the ramp state and compares each output request with the oldest prediction.
// Depends on bfr_pkg.
module brightness_fade_ramp_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] frames
    input  logic [1:0] s_axis_tuser,    // [1:0] func
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,    // [3:0] brightness, [4] active, [7:5] zero
    output int         fail_count,
    output int         outstanding
);

    typedef struct packed {
        logic [bfr_pkg::BRIGHT_W-1:0] brightness;
        logic                         active;
    } fade_level_t;

    logic                         ramp_running;
    logic                         ramp_up;
    logic [bfr_pkg::ACC_W-1:0]    ramp_acc;
    logic [bfr_pkg::STEP_W-1:0]   ramp_step;
    logic [bfr_pkg::BRIGHT_W-1:0] ramp_shown;

    fade_level_t expected_levels[$];

    // Applies one command to the ramp state and returns the level it reports.
    function automatic fade_level_t advance_ramp(logic [1:0] cmd,
                                                 logic [bfr_pkg::FRAMES_W-1:0] frames);
        fade_level_t               level;
        logic [bfr_pkg::ACC_W-1:0] quot;
        case (cmd)
            bfr_pkg::FUNC_TICK:
            begin
                if (ramp_running)
                begin
                    if (ramp_up)
                    begin
                        ramp_acc = ramp_acc + bfr_pkg::ACC_W'(ramp_step);
                        if (ramp_acc >= bfr_pkg::FULL_LEVEL)
                        begin
                            ramp_acc     = bfr_pkg::FULL_LEVEL;
                            ramp_running = 1'b0;
                        end
                    end
                    else if (ramp_acc <= bfr_pkg::ACC_W'(ramp_step))
                    begin
                        ramp_acc     = '0;
                        ramp_running = 1'b0;
                    end
                    else
                    begin
                        ramp_acc = ramp_acc - bfr_pkg::ACC_W'(ramp_step);
                    end
                    if (ramp_acc[bfr_pkg::ACC_W-1:8] >
                        (bfr_pkg::ACC_W-8)'(bfr_pkg::MAX_BRIGHT))
                        ramp_shown = bfr_pkg::MAX_BRIGHT;
                    else
                        ramp_shown = ramp_acc[11:8];
                end
            end
            bfr_pkg::FUNC_FADE_IN, bfr_pkg::FUNC_FADE_OUT:
            begin
                if (frames == '0)
                begin
                    // A zero-length fade lands on its end level at once.
                    ramp_shown   = (cmd == bfr_pkg::FUNC_FADE_IN) ? bfr_pkg::MAX_BRIGHT : '0;
                    ramp_running = 1'b0;
                end
                else
                begin
                    ramp_running = 1'b1;
                    ramp_up      = (cmd == bfr_pkg::FUNC_FADE_IN);
                    ramp_acc     = ramp_up ? '0 : bfr_pkg::FULL_LEVEL;
                    quot         = bfr_pkg::FULL_LEVEL / bfr_pkg::ACC_W'(frames);
                    ramp_step    = quot[bfr_pkg::STEP_W-1:0];
                    if (ramp_step == '0)
                        ramp_step = bfr_pkg::STEP_W'(1);
                    ramp_shown   = ramp_up ? '0 : bfr_pkg::MAX_BRIGHT;
                end
            end
            default: ;
        endcase
        level.brightness = ramp_shown;
        level.active     = ramp_running;
        return level;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fade_level_t want;
        if (!rst_n)
        begin
            ramp_running = 1'b0;
            ramp_up      = 1'b0;
            ramp_acc     = '0;
            ramp_step    = '0;
            ramp_shown   = '0;
            fail_count   = 0;
            expected_levels.delete();
        end
        else
        begin
            // Results are checked before the new request is predicted, so an
            // early result can never be matched against its own prediction.
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_levels.size() == 0)
                begin
                    $error("unexpected result request, tdata %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_levels.pop_front();
                    if (m_axis_tdata[bfr_pkg::BRIGHT_W-1:0] !== want.brightness)
                    begin
                        $error("brightness: expected %0d, got %0d",
                               want.brightness, m_axis_tdata[bfr_pkg::BRIGHT_W-1:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[bfr_pkg::BRIGHT_W] !== want.active)
                    begin
                        $error("active: expected %0d, got %0d",
                               want.active, m_axis_tdata[bfr_pkg::BRIGHT_W]);
                        fail_count++;
                    end
                    if (m_axis_tdata[7:bfr_pkg::BRIGHT_W+1] !== '0)
                    begin
                        $error("pad: expected 0, got %0d",
                               m_axis_tdata[7:bfr_pkg::BRIGHT_W+1]);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_levels.push_back(advance_ramp(s_axis_tuser, s_axis_tdata));
        end
        outstanding = expected_levels.size();
    end

endmodule

// ===== dv/testbench.sv =====
// Top of the brightness fade ramp testbench: clock, reset, command stimulus and result sink.
// Prediction and comparison live in brightness_fade_ramp_checker.
// Depends on bfr_pkg, brightness_fade_ramp_top and brightness_fade_ramp_checker.
module testbench;

    // The package names three commands; the fourth selector value is unused
    // and must be ignored by the block.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Rough count of command requests to send before draining.
    localparam int REQUEST_TARGET = 1050;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;      // [7:0] frames
    logic [1:0] s_axis_tuser = '0;      // [1:0] func
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [3:0] brightness, [4] active, [7:5] zero

    int fail_count;
    int outstanding;
    int requests_sent = 0;
    bit sender_steady = 1'b0;

    brightness_fade_ramp_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    brightness_fade_ramp_checker checker_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Idle length for either side. Most gaps are zero or a few cycles; now and
    // then a long one lets the other side drain or fill completely. In steady
    // mode there is no idling at all, which gives back-to-back stretches.
    function automatic int idle_cycles(bit steady);
        int pick;
        if (steady)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        if (pick < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Presents one command request and holds it until the block takes it. The
    // valid stays high straight into the next request when no gap is drawn, so
    // it is never dropped and raised again within one time step.
    task automatic send_request(logic [1:0] cmd, logic [7:0] frames);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= frames;
        do
            @(posedge clk);
        while (!s_axis_tready);
        requests_sent++;
        gap = idle_cycles(sender_steady);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // A tick carries random frames, which the block must ignore.
    task automatic send_tick();
        send_request(bfr_pkg::FUNC_TICK, 8'($urandom));
    endtask

    // One fade: a start followed by a run of ticks, sometimes long enough to
    // reach the end and coast past it, sometimes cut short by the next start.
    // An odd unused selector is mixed in now and then while the ramp runs.
    task automatic send_fade();
        int          pick;
        int          ticks;
        logic [7:0]  frames;
        logic [1:0]  dir;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            frames = 8'($urandom_range(1, 24));
        else if (pick < 90)
            frames = 8'($urandom_range(25, 255));
        else
            frames = 8'($urandom_range(1, 255));
        dir = $urandom_range(0, 1) ? bfr_pkg::FUNC_FADE_IN : bfr_pkg::FUNC_FADE_OUT;
        send_request(dir, frames);
        if (frames <= 24)
            ticks = $urandom_range(0, frames + 3);
        else if ($urandom_range(0, 9) == 0)
            ticks = frames + 2;
        else
            ticks = $urandom_range(0, 30);
        repeat (ticks)
        begin
            if ($urandom_range(0, 19) == 0)
                send_request(FUNC_UNUSED, 8'($urandom));
            else
                send_tick();
        end
    endtask

    // Reset is held low from the start and released at a clock edge.
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Result sink: ready runs of random length broken by stalls, with an
    // occasional long stretch of ready held high.
    initial
    begin
        bit steady;
        int run_len;
        int stall;
        @(posedge clk);
        forever
        begin
            steady  = ($urandom_range(0, 7) == 0);
            run_len = $urandom_range(1, steady ? 200 : 8);
            m_axis_tready <= 1'b1;
            repeat (run_len) @(posedge clk);
            stall = idle_cycles(steady);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Command stimulus: a directed opening, then random fades and noise, then
    // a drain and the verdict.
    initial
    begin
        int pick;
        @(posedge rst_n);
        @(posedge clk);

        // Commands right after reset, while nothing is running.
        send_tick();
        send_request(FUNC_UNUSED, 8'hFF);
        // Zero-length fades jump to their end level and leave the ramp idle.
        send_request(bfr_pkg::FUNC_FADE_IN, 8'd0);
        send_tick();
        send_request(bfr_pkg::FUNC_FADE_OUT, 8'd0);
        // One-frame fades: the whole range in a single step, then clamped.
        send_request(bfr_pkg::FUNC_FADE_IN, 8'd1);
        send_tick();
        send_tick();
        send_request(bfr_pkg::FUNC_FADE_OUT, 8'd1);
        send_tick();
        // Longest fade, interrupted by an unused selector and by a new start.
        send_request(bfr_pkg::FUNC_FADE_IN, 8'd255);
        send_tick();
        send_request(FUNC_UNUSED, 8'h00);
        send_request(bfr_pkg::FUNC_FADE_OUT, 8'hAA);
        send_tick();
        send_request(bfr_pkg::FUNC_FADE_IN, 8'h55);
        send_tick();
        // Fade-out whose last step lands exactly on black.
        send_request(bfr_pkg::FUNC_FADE_OUT, 8'd3);
        send_tick();
        send_tick();
        send_tick();
        send_request(bfr_pkg::FUNC_FADE_IN, 8'h80);
        send_tick();
        send_request(bfr_pkg::FUNC_FADE_OUT, 8'd2);
        send_tick();
        send_tick();

        while (requests_sent < REQUEST_TARGET)
        begin
            if ($urandom_range(0, 7) == 0)
                sender_steady = ~sender_steady;
            pick = $urandom_range(0, 99);
            if (pick < 80)
                send_fade();
            else if (pick < 90)
                send_request($urandom_range(0, 1) ? bfr_pkg::FUNC_FADE_IN :
                             bfr_pkg::FUNC_FADE_OUT, 8'd0);
            else if (pick < 95)
                send_request(FUNC_UNUSED, 8'($urandom));
            else
                send_tick();
        end
        s_axis_tvalid <= 1'b0;

        // Drain: every predicted result must come back, then a short quiet
        // spell catches any stray extra result. The first edge lets the
        // checker count the last request before the count is read.
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hard limit: several times the slowest legal run, in which every request
    // meets the longest sender gap, the longest sink stall and the divider.
    initial
    begin
        #6000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== brightness_fade_ramp_top.f =====
hw/rtl/bfr_pkg.sv
hw/rtl/bfr_div.sv
hw/rtl/brightness_fade_ramp_top.sv
dv/brightness_fade_ramp_checker.sv
dv/testbench.sv
